// File: hdl/kth_missing_value_search_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the k-th missing value search core
// Shared shorthands for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef KTH_MISSING_VALUE_SEARCH_CORE_DEFINES_SVH
`define KTH_MISSING_VALUE_SEARCH_CORE_DEFINES_SVH

// Check a property on every rising clock edge outside reset
`define KMV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle
`define KMV_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the next cycle
`define KMV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/kmv_pkg.sv
// ----------------------------------------------------------------------------
// kmv_pkg
// Types, codes and the sequencer program of the k-th missing value search.
// ----------------------------------------------------------------------------
package kmv_pkg;

	localparam int VAL_W = 48;
	localparam int ANS_W = 49;

	// Operation codes of an input item
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NOP    = 2'd3
	} kmv_op_t;

	// Status codes of a result item
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_ORDER = 2'd2
	} kmv_status_t;

	typedef struct packed {
		logic [1:0]       operation;
		logic [VAL_W-1:0] entry_value;
		logic [VAL_W-1:0] query_rank;
	} kmv_in_t;

	typedef struct packed {
		logic [ANS_W-1:0] answer;
		logic [1:0]       status;
	} kmv_out_t;

	// Program step addresses
	typedef logic [3:0] kmv_pc_t;

	localparam kmv_pc_t PC_FETCH   = 4'd0;
	localparam kmv_pc_t PC_CLEAR   = 4'd1;
	localparam kmv_pc_t PC_NOP     = 4'd2;
	localparam kmv_pc_t PC_APPEND  = 4'd3;
	localparam kmv_pc_t PC_PROBE   = 4'd4;
	localparam kmv_pc_t PC_STEP    = 4'd5;
	localparam kmv_pc_t PC_RD_CUR  = 4'd6;
	localparam kmv_pc_t PC_RD_PREV = 4'd7;
	localparam kmv_pc_t PC_ANSWER  = 4'd8;

	// Datapath action of one control word
	typedef enum logic [3:0] {
		ACT_FETCH,
		ACT_CLEAR,
		ACT_NOP,
		ACT_APPEND,
		ACT_PROBE,
		ACT_STEP,
		ACT_RD_CUR,
		ACT_RD_PREV,
		ACT_ANSWER
	} kmv_act_t;

	// Sequencing condition of one control word
	typedef enum logic [2:0] {
		CND_NEXT,     // go to pc + 1
		CND_DISPATCH, // on accept, go to the entry step of the operation
		CND_EMIT,     // when the result slot is free, go to target, else hold
		CND_DONE,     // search range empty: go to target, else pc + 1
		CND_LIVE      // search range still open: go to target, else pc + 1
	} kmv_cond_t;

	typedef struct packed {
		kmv_act_t  act;
		kmv_cond_t cond;
		kmv_pc_t   target;
	} kmv_uword_t;

	// Control store
	function automatic kmv_uword_t kmv_ucode(kmv_pc_t pc);
		kmv_uword_t w;
		unique case (pc)
			PC_FETCH:   w = '{ACT_FETCH,   CND_DISPATCH, PC_FETCH};
			PC_CLEAR:   w = '{ACT_CLEAR,   CND_EMIT,     PC_FETCH};
			PC_NOP:     w = '{ACT_NOP,     CND_EMIT,     PC_FETCH};
			PC_APPEND:  w = '{ACT_APPEND,  CND_EMIT,     PC_FETCH};
			PC_PROBE:   w = '{ACT_PROBE,   CND_DONE,     PC_RD_CUR};
			PC_STEP:    w = '{ACT_STEP,    CND_LIVE,     PC_STEP};
			PC_RD_CUR:  w = '{ACT_RD_CUR,  CND_NEXT,     PC_FETCH};
			PC_RD_PREV: w = '{ACT_RD_PREV, CND_NEXT,     PC_FETCH};
			PC_ANSWER:  w = '{ACT_ANSWER,  CND_EMIT,     PC_FETCH};
			default:    w = '{ACT_FETCH,   CND_EMIT,     PC_FETCH};
		endcase
		return w;
	endfunction

	// Dispatch table: entry step of each operation
	function automatic kmv_pc_t kmv_entry(kmv_op_t op);
		kmv_pc_t pc;
		unique case (op)
			OP_CLEAR:  pc = PC_CLEAR;
			OP_APPEND: pc = PC_APPEND;
			OP_QUERY:  pc = PC_PROBE;
			default:   pc = PC_NOP;
		endcase
		return pc;
	endfunction

endpackage

// File: hdl/kth_missing_value_search_core.sv
// ----------------------------------------------------------------------------
// kth_missing_value_search_core
// Table of strictly increasing values with a k-th missing integer query.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on item_valid/item_ready; each gives one result item on
//   result_valid/result_ready. Operation clear empties the table, append adds
//   a value (status full, or order for a zero or non-increasing value, when
//   refused), query returns the k-th positive integer absent from the table.
//   One item is in work at a time. Clear, append and unknown codes give their
//   result from their entry step. A query runs a binary search of s probes,
//   where s is ceil(log2(count + 1)) at most (11 for a full table of 1024
//   entries): the search makes one read of the entry RAM per cycle, then up
//   to two reads form the answer.
//   A finished result sits in an output register; the next item is accepted
//   while it waits. If the receiver stalls, the following result is held in
//   its final step until the register is free.
//   Reset empties the table and drops any pending result. The entry RAM
//   needs no clearing: only entries below the count are ever read.
// ----------------------------------------------------------------------------
`include "kth_missing_value_search_core_defines.svh"

module kth_missing_value_search_core #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  kmv_pkg::kmv_in_t  item,
	output logic              result_valid,
	input  logic              result_ready,
	output kmv_pkg::kmv_out_t result
);

	import kmv_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int MW = 2 * VAL_W;

	// Sequencer and control state
	kmv_pc_t        pc_q, pc_d;
	logic [CW-1:0]  count_q, count_d;
	logic           result_valid_q, result_valid_d;

	// Datapath registers
	logic [VAL_W-1:0] val_q, k_q, last_val_q, last_miss_q, cur_val_q;
	logic [CW-1:0]    lo_q, hi_q;
	logic [AW-1:0]    mid_q;
	logic             cur_hit_q;
	kmv_out_t         result_q;

	// Next values
	logic [VAL_W-1:0] val_d, k_d, last_val_d, last_miss_d, cur_val_d;
	logic [CW-1:0]    lo_d, hi_d;
	logic [AW-1:0]    mid_d;
	logic             cur_hit_d;
	kmv_out_t         result_d;

	kmv_uword_t uw;
	logic       slot_free;
	logic       accept;
	logic       range_open;

	// RAM ports
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [MW-1:0] ram_wdata, ram_rdata;
	logic [VAL_W-1:0] rd_val, rd_miss;

	// Append arithmetic
	logic             tab_full, order_bad;
	logic [VAL_W-1:0] base_val, base_miss, new_miss;

	// Search arithmetic
	logic [CW-1:0]    probe_mid, lo_n, hi_n, step_mid;
	logic [VAL_W-1:0] rank_gap;

	assign rd_val  = ram_rdata[MW-1:VAL_W];
	assign rd_miss = ram_rdata[VAL_W-1:0];

	assign uw        = kmv_ucode(pc_q);
	assign slot_free = !result_valid_q || result_ready;
	assign accept    = item_valid && item_ready;

	// Append: missing count = previous count + gap to previous value
	assign tab_full  = (count_q == CW'(TABLE_DEPTH));
	assign base_val  = (count_q == '0) ? '0 : last_val_q;
	assign base_miss = (count_q == '0) ? '0 : last_miss_q;
	assign order_bad = (val_q == '0) || ((count_q != '0) && (val_q <= last_val_q));
	assign new_miss  = base_miss + val_q + ~base_val;

	// Search: midpoint of the current range, and range after one compare
	assign probe_mid = lo_q + ((hi_q - lo_q) >> 1);
	always_comb begin
		if (rd_miss < k_q) begin
			lo_n = {{(CW-AW){1'b0}}, mid_q} + CW'(1);
			hi_n = hi_q;
		end else begin
			lo_n = lo_q;
			hi_n = {{(CW-AW){1'b0}}, mid_q};
		end
	end
	assign step_mid   = lo_n + ((hi_n - lo_n) >> 1);
	assign range_open = (lo_n < hi_n);
	assign rank_gap   = k_q - rd_miss;

	// Datapath actions of the current control word
	always_comb begin
		item_ready     = 1'b0;
		result_valid_d = result_valid_q;
		count_d        = count_q;
		val_d          = val_q;
		k_d            = k_q;
		last_val_d     = last_val_q;
		last_miss_d    = last_miss_q;
		cur_val_d      = cur_val_q;
		cur_hit_d      = cur_hit_q;
		lo_d           = lo_q;
		hi_d           = hi_q;
		mid_d          = mid_q;
		result_d       = result_q;
		ram_we         = 1'b0;
		ram_waddr      = count_q[AW-1:0];
		ram_wdata      = {val_q, new_miss};
		ram_re         = 1'b0;
		ram_raddr      = mid_q;

		// Drop the result once taken
		if (result_valid_q && result_ready) begin
			result_valid_d = 1'b0;
		end

		unique case (uw.act)
			ACT_FETCH: begin
				item_ready = 1'b1;
				if (item_valid) begin
					val_d = item.entry_value;
					k_d   = item.query_rank;
					lo_d  = '0;
					hi_d  = count_q;
				end
			end
			ACT_CLEAR: begin
				if (slot_free) begin
					count_d        = '0;
					result_d       = '{answer: '0, status: ST_OK};
					result_valid_d = 1'b1;
				end
			end
			ACT_NOP: begin
				if (slot_free) begin
					result_d       = '{answer: '0, status: ST_OK};
					result_valid_d = 1'b1;
				end
			end
			ACT_APPEND: begin
				if (slot_free) begin
					result_valid_d = 1'b1;
					result_d.answer = '0;
					if (tab_full) begin
						result_d.status = ST_FULL;
					end else if (order_bad) begin
						result_d.status = ST_ORDER;
					end else begin
						result_d.status = ST_OK;
						ram_we          = 1'b1;
						count_d         = count_q + CW'(1);
						last_val_d      = val_q;
						last_miss_d     = new_miss;
					end
				end
			end
			ACT_PROBE: begin
				// Issue the first read while the range is open
				if (lo_q < hi_q) begin
					ram_re    = 1'b1;
					ram_raddr = probe_mid[AW-1:0];
					mid_d     = probe_mid[AW-1:0];
				end
			end
			ACT_STEP: begin
				// Narrow the range and read the next midpoint
				lo_d = lo_n;
				hi_d = hi_n;
				if (range_open) begin
					ram_re    = 1'b1;
					ram_raddr = step_mid[AW-1:0];
					mid_d     = step_mid[AW-1:0];
				end
			end
			ACT_RD_CUR: begin
				if (lo_q < count_q) begin
					ram_re    = 1'b1;
					ram_raddr = lo_q[AW-1:0];
				end
			end
			ACT_RD_PREV: begin
				// Hold the found entry, read the one before it
				cur_hit_d = (lo_q < count_q) && (rd_miss == k_q);
				cur_val_d = rd_val;
				if (lo_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(lo_q - CW'(1));
				end
			end
			ACT_ANSWER: begin
				if (slot_free) begin
					result_valid_d  = 1'b1;
					result_d.status = ST_OK;
					if (cur_hit_q) begin
						result_d.answer = {1'b0, cur_val_q - VAL_W'(1)};
					end else if (lo_q == '0) begin
						result_d.answer = {1'b0, k_q};
					end else begin
						result_d.answer = {1'b0, rd_val} + {1'b0, rank_gap};
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Next step
	always_comb begin
		pc_d = pc_q + kmv_pc_t'(1);
		unique case (uw.cond)
			CND_NEXT: begin
				pc_d = pc_q + kmv_pc_t'(1);
			end
			CND_DISPATCH: begin
				pc_d = item_valid ? kmv_entry(kmv_op_t'(item.operation)) : pc_q;
			end
			CND_EMIT: begin
				pc_d = slot_free ? uw.target : pc_q;
			end
			CND_DONE: begin
				if (!(lo_q < hi_q)) begin
					pc_d = uw.target;
				end
			end
			CND_LIVE: begin
				if (range_open) begin
					pc_d = uw.target;
				end
			end
			default: begin
				pc_d = PC_FETCH;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q           <= PC_FETCH;
			count_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			pc_q           <= pc_d;
			count_q        <= count_d;
			result_valid_q <= result_valid_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		val_q       <= val_d;
		k_q         <= k_d;
		last_val_q  <= last_val_d;
		last_miss_q <= last_miss_d;
		cur_val_q   <= cur_val_d;
		cur_hit_q   <= cur_hit_d;
		lo_q        <= lo_d;
		hi_q        <= hi_d;
		mid_q       <= mid_d;
		result_q    <= result_d;
	end

	// Entry table: value and missing count per entry
	kmv_ram #(
		.WIDTH (MW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Assertions
	`KMV_ASSERT(a_count_bound, count_q <= CW'(TABLE_DEPTH), "entry count beyond table depth")
	`KMV_ASSERT_IMPLY(a_search_range, (pc_q == PC_PROBE) || (pc_q == PC_STEP),
		(lo_q <= hi_q) && (hi_q <= count_q), "search range out of order")
	`KMV_ASSERT_NEXT(a_one_item, accept, !item_ready, "second item taken while one in work")
	`KMV_ASSERT_IMPLY(a_write_in_range, ram_we, count_q < CW'(TABLE_DEPTH),
		"table write past last entry")

endmodule

// File: hdl/kmv_ram.sv
// ----------------------------------------------------------------------------
// kmv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kmv_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
